[rtl/prf_pkg.sv]
// shared types and constants for the ip/port range filter
`default_nettype none

package prf_pkg;

    // entries in each of the ip, tcp, udp and protocol tables
    localparam int TABLE_ENTRIES = 16;

    localparam int FUNC_W  = 3;
    localparam int SLOT_W  = 4;
    localparam int ADDR_W  = 32;
    localparam int PORT_W  = 16;
    localparam int PROTO_W = 8;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam int REG_W   = 2;

    localparam logic [FUNC_W-1:0] FUNC_LOAD_IP    = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOAD_TCP   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_LOAD_UDP   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_LOAD_PROTO = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR      = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP     = 3'd5;

    // register index, taken from paddr[3:2]
    localparam logic [REG_W-1:0] REG_ALL_APPS = 2'd0;
    localparam logic [REG_W-1:0] REG_TCP_CODE = 2'd1;
    localparam logic [REG_W-1:0] REG_UDP_CODE = 2'd2;

    localparam logic [PROTO_W-1:0] TCP_CODE_RESET = 8'd6;
    localparam logic [PROTO_W-1:0] UDP_CODE_RESET = 8'd17;

    typedef struct packed {
        logic capture;  // latch the accepted word
        logic eval;     // write tables, register per-table hits
        logic finish;   // combine hits into the output register
    } cmd_t;

endpackage

`default_nettype wire

[rtl/prf_ctrl.sv]
// controller state machine: sequences capture, evaluate and result load
`default_nettype none

module prf_ctrl (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  wire               out_ready,
    output prf_pkg::cmd_t     cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        in_ready       = 1'b0;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // wait until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

[rtl/prf_dp.sv]
// datapath: range tables, per-entry comparators and result register
`default_nettype none

module prf_dp (
    input  wire                              clk,
    input  wire                              rst_n,
    input  prf_pkg::cmd_t                    cmd,
    input  wire  [prf_pkg::FUNC_W-1:0]       func,
    input  wire  [prf_pkg::SLOT_W-1:0]       slot,
    input  wire  [prf_pkg::ADDR_W-1:0]       range_low,
    input  wire  [prf_pkg::ADDR_W-1:0]       range_high,
    input  wire  [prf_pkg::ADDR_W-1:0]       packet_ip,
    input  wire  [prf_pkg::PORT_W-1:0]       packet_port,
    input  wire  [prf_pkg::PROTO_W-1:0]      packet_proto,
    input  wire                              all_apps,
    input  wire  [prf_pkg::PROTO_W-1:0]      tcp_code,
    input  wire  [prf_pkg::PROTO_W-1:0]      udp_code,
    output logic                             matched
);

    localparam int N = prf_pkg::TABLE_ENTRIES;

    // captured word
    logic [prf_pkg::FUNC_W-1:0]  func_reg;
    logic [prf_pkg::SLOT_W-1:0]  slot_reg;
    logic [prf_pkg::ADDR_W-1:0]  lo_reg;
    logic [prf_pkg::ADDR_W-1:0]  hi_reg;
    logic [prf_pkg::ADDR_W-1:0]  ip_reg;
    logic [prf_pkg::PORT_W-1:0]  port_reg;
    logic [prf_pkg::PROTO_W-1:0] proto_reg;

    // tables
    logic [prf_pkg::ADDR_W-1:0]  ip_lo_reg    [N];
    logic [prf_pkg::ADDR_W-1:0]  ip_hi_reg    [N];
    logic [prf_pkg::PORT_W-1:0]  tcp_lo_reg   [N];
    logic [prf_pkg::PORT_W-1:0]  tcp_hi_reg   [N];
    logic [prf_pkg::PORT_W-1:0]  udp_lo_reg   [N];
    logic [prf_pkg::PORT_W-1:0]  udp_hi_reg   [N];
    logic [prf_pkg::PROTO_W-1:0] proto_lst_reg[N];
    logic [N-1:0] ip_ok_reg;
    logic [N-1:0] ip_ok_next;
    logic [N-1:0] tcp_ok_reg;
    logic [N-1:0] tcp_ok_next;
    logic [N-1:0] udp_ok_reg;
    logic [N-1:0] udp_ok_next;
    logic [N-1:0] proto_ok_reg;
    logic [N-1:0] proto_ok_next;

    // per-table hits
    logic ip_hit_reg;
    logic tcp_hit_reg;
    logic udp_hit_reg;
    logic proto_hit_reg;
    logic lookup_reg;
    logic matched_reg;
    logic matched_next;

    logic [N-1:0] wr_sel;
    logic [N-1:0] ip_lane;
    logic [N-1:0] tcp_lane;
    logic [N-1:0] udp_lane;
    logic [N-1:0] proto_lane;
    logic         is_ip;
    logic         is_tcp;
    logic         is_udp;
    logic         is_proto;
    logic         is_clear;

    assign is_ip    = (func_reg == prf_pkg::FUNC_LOAD_IP);
    assign is_tcp   = (func_reg == prf_pkg::FUNC_LOAD_TCP);
    assign is_udp   = (func_reg == prf_pkg::FUNC_LOAD_UDP);
    assign is_proto = (func_reg == prf_pkg::FUNC_LOAD_PROTO);
    assign is_clear = (func_reg == prf_pkg::FUNC_CLEAR);

    // one comparator lane per entry
    always_comb
    begin
        for (int e = 0; e < N; e++)
        begin
            wr_sel[e]     = ({{(32-prf_pkg::SLOT_W){1'b0}}, slot_reg} == 32'(e));
            ip_lane[e]    = ip_ok_reg[e] && (ip_lo_reg[e] <= ip_reg)
                            && (ip_reg <= ip_hi_reg[e]);
            tcp_lane[e]   = tcp_ok_reg[e] && (tcp_lo_reg[e] <= port_reg)
                            && (port_reg <= tcp_hi_reg[e]);
            udp_lane[e]   = udp_ok_reg[e] && (udp_lo_reg[e] <= port_reg)
                            && (port_reg <= udp_hi_reg[e]);
            proto_lane[e] = proto_ok_reg[e] && (proto_lst_reg[e] == proto_reg);
        end
    end

    always_comb
    begin
        ip_ok_next    = ip_ok_reg;
        tcp_ok_next   = tcp_ok_reg;
        udp_ok_next   = udp_ok_reg;
        proto_ok_next = proto_ok_reg;
        if (cmd.eval)
        begin
            if (is_clear)
            begin
                ip_ok_next    = '0;
                tcp_ok_next   = '0;
                udp_ok_next   = '0;
                proto_ok_next = '0;
            end
            if (is_ip)
            begin
                ip_ok_next = ip_ok_reg | wr_sel;
            end
            if (is_tcp)
            begin
                tcp_ok_next = tcp_ok_reg | wr_sel;
            end
            if (is_udp)
            begin
                udp_ok_next = udp_ok_reg | wr_sel;
            end
            if (is_proto)
            begin
                proto_ok_next = proto_ok_reg | wr_sel;
            end
        end
    end

    // tcp table wins when both codes are equal
    always_comb
    begin
        if (!lookup_reg || !ip_hit_reg)
        begin
            matched_next = 1'b0;
        end
        else if (all_apps)
        begin
            matched_next = 1'b1;
        end
        else if (proto_reg == tcp_code)
        begin
            matched_next = tcp_hit_reg;
        end
        else if (proto_reg == udp_code)
        begin
            matched_next = udp_hit_reg;
        end
        else
        begin
            matched_next = proto_hit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg  <= func;
            slot_reg  <= slot;
            lo_reg    <= range_low;
            hi_reg    <= range_high;
            ip_reg    <= packet_ip;
            port_reg  <= packet_port;
            proto_reg <= packet_proto;
        end
        if (cmd.eval)
        begin
            ip_hit_reg    <= |ip_lane;
            tcp_hit_reg   <= |tcp_lane;
            udp_hit_reg   <= |udp_lane;
            proto_hit_reg <= |proto_lane;
            lookup_reg    <= (func_reg == prf_pkg::FUNC_LOOKUP);
            for (int e = 0; e < N; e++)
            begin
                if (wr_sel[e] && is_ip)
                begin
                    ip_lo_reg[e] <= lo_reg;
                    ip_hi_reg[e] <= hi_reg;
                end
                if (wr_sel[e] && is_tcp)
                begin
                    tcp_lo_reg[e] <= lo_reg[prf_pkg::PORT_W-1:0];
                    tcp_hi_reg[e] <= hi_reg[prf_pkg::PORT_W-1:0];
                end
                if (wr_sel[e] && is_udp)
                begin
                    udp_lo_reg[e] <= lo_reg[prf_pkg::PORT_W-1:0];
                    udp_hi_reg[e] <= hi_reg[prf_pkg::PORT_W-1:0];
                end
                if (wr_sel[e] && is_proto)
                begin
                    proto_lst_reg[e] <= lo_reg[prf_pkg::PROTO_W-1:0];
                end
            end
        end
        if (cmd.finish)
        begin
            matched_reg <= matched_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ip_ok_reg    <= '0;
            tcp_ok_reg   <= '0;
            udp_ok_reg   <= '0;
            proto_ok_reg <= '0;
        end
        else
        begin
            ip_ok_reg    <= ip_ok_next;
            tcp_ok_reg   <= tcp_ok_next;
            udp_ok_reg   <= udp_ok_next;
            proto_ok_reg <= proto_ok_next;
        end
    end

    assign matched = matched_reg;

endmodule

`default_nettype wire

[rtl/ip_port_range_filter.sv]
// Packet filter rule matcher: IPv4 address ranges plus TCP/UDP port ranges and a
// list of other protocol codes, each table 16 entries deep with valid bits that
// reset and the clear word drop. Every word (load, clear or lookup) returns one
// result word; matched is 1 only for a lookup that hits. An accepted word is first
// captured, then all entries of every table are compared in parallel and the table
// write happens, and then the hits are combined into the output register once that
// register is free. A new word is taken only after the last one has reached the
// output register, which lets the next word enter while a result still waits.
// all_apps, tcp_code and udp_code sit at APB offsets 0x0, 0x4 and 0x8; the user is
// to write them only while the block is idle, which the block does not enforce.
`default_nettype none

module ip_port_range_filter (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [prf_pkg::PADDR_W-1:0]      paddr,
    input  wire  [prf_pkg::PDATA_W-1:0]      pwdata,
    output logic [prf_pkg::PDATA_W-1:0]      prdata,
    output logic                             pready,
    input  wire                              in_valid,
    output logic                             in_ready,
    input  wire  [prf_pkg::FUNC_W-1:0]       func,
    input  wire  [prf_pkg::SLOT_W-1:0]       slot,
    input  wire  [prf_pkg::ADDR_W-1:0]       range_low,
    input  wire  [prf_pkg::ADDR_W-1:0]       range_high,
    input  wire  [prf_pkg::ADDR_W-1:0]       packet_ip,
    input  wire  [prf_pkg::PORT_W-1:0]       packet_port,
    input  wire  [prf_pkg::PROTO_W-1:0]      packet_proto,
    output logic                             out_valid,
    input  wire                              out_ready,
    output logic                             matched
);

    logic                         all_apps_reg;
    logic [prf_pkg::PROTO_W-1:0]  tcp_code_reg;
    logic [prf_pkg::PROTO_W-1:0]  udp_code_reg;
    logic                         cfg_wr;
    logic [prf_pkg::REG_W-1:0]    reg_idx;
    prf_pkg::cmd_t                cmd;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[prf_pkg::PADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            all_apps_reg <= 1'b1;
            tcp_code_reg <= prf_pkg::TCP_CODE_RESET;
            udp_code_reg <= prf_pkg::UDP_CODE_RESET;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                prf_pkg::REG_ALL_APPS: all_apps_reg <= pwdata[0];
                prf_pkg::REG_TCP_CODE: tcp_code_reg <= pwdata[prf_pkg::PROTO_W-1:0];
                prf_pkg::REG_UDP_CODE: udp_code_reg <= pwdata[prf_pkg::PROTO_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            prf_pkg::REG_ALL_APPS:
                prdata = {{(prf_pkg::PDATA_W-1){1'b0}}, all_apps_reg};
            prf_pkg::REG_TCP_CODE:
                prdata = {{(prf_pkg::PDATA_W-prf_pkg::PROTO_W){1'b0}}, tcp_code_reg};
            prf_pkg::REG_UDP_CODE:
                prdata = {{(prf_pkg::PDATA_W-prf_pkg::PROTO_W){1'b0}}, udp_code_reg};
            default:
                prdata = '0;
        endcase
    end

    prf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    prf_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .func         (func),
        .slot         (slot),
        .range_low    (range_low),
        .range_high   (range_high),
        .packet_ip    (packet_ip),
        .packet_port  (packet_port),
        .packet_proto (packet_proto),
        .all_apps     (all_apps_reg),
        .tcp_code     (tcp_code_reg),
        .udp_code     (udp_code_reg),
        .matched      (matched)
    );

`ifndef ASSERT_OFF
    // one word in flight at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("word accepted while previous one still in flight");

    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.capture, cmd.eval, cmd.finish}))
        else $error("controller issued overlapping commands");

    // result load never overwrites an undrained result
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid || out_ready))
        else $error("result register overwritten before drain");

    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr && reg_idx == prf_pkg::REG_ALL_APPS |=> all_apps_reg == $past(pwdata[0]))
        else $error("all_apps write lost");
`endif

endmodule

`default_nettype wire
